FILE: src/abkf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_pkg: shared types and helpers of the angle/bias Kalman filter
// Word formats, register indexes, datapath operation codes and fixed-point
// rounding and saturation helpers.
// ----------------------------------------------------------------------------
package abkf_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 31;
	localparam int unsigned DivSteps = 31;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	localparam logic [CfgIdxW-1:0] RegAngleNoise   = 2'd0;
	localparam logic [CfgIdxW-1:0] RegBiasNoise    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegMeasureNoise = 2'd2;

	localparam logic [CfgDataW-1:0] AngleNoiseRst   = 31'd16777;
	localparam logic [CfgDataW-1:0] BiasNoiseRst    = 31'd50332;
	localparam logic [CfgDataW-1:0] MeasureNoiseRst = 31'd503316;

	localparam logic signed [31:0] OneQ24 = 32'sd16777216;
	localparam logic signed [31:0] Max32  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Min32  = 32'sh8000_0000;

	localparam logic ActUpdate = 1'b0;
	localparam logic ActReset  = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] measured_angle;
		logic signed [31:0] gyro_rate;
		logic        [15:0] time_step;
		logic signed [31:0] start_angle;
		logic signed [31:0] start_bias;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] filtered_angle;
		logic signed [31:0] estimated_bias;
	} out_word_t;

	// multiply and write-back operations of the shared multiplier
	typedef enum logic [3:0] {
		OP_RATE,
		OP_DT_P11,
		OP_DT_INNER,
		OP_DT_BN,
		OP_K0Y,
		OP_K1Y,
		OP_K1P00,
		OP_K1P01,
		OP_K0P00,
		OP_K0P01
	} mul_op_t;

	typedef struct packed {
		logic    take;
		logic    load_rst;
		logic    mul;
		logic    wb;
		mul_op_t op;
		logic    div_init;
		logic    div_step;
		logic    div_fin;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_stat_t;

	function automatic logic signed [69:0] sx70(input logic signed [31:0] v);
		return {{38{v[31]}}, v};
	endfunction

	// round half up of x / 2^n
	function automatic logic signed [69:0] rnd_shr(input logic signed [68:0] x,
			input int unsigned n);
		logic signed [69:0] e;
		e = {x[68], x};
		e = e + (70'sd1 <<< (n - 1));
		return e >>> n;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [69:0] x);
		if (x > sx70(Max32)) return Max32;
		if (x < sx70(Min32)) return Min32;
		return x[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/abkf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_ctrl: sequencer of the filter
// Steps the datapath through prediction, gain division and correction, or the reset load, and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module abkf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             action,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output abkf_pkg::dp_cmd_t     cmd,
	input  wire abkf_pkg::dp_stat_t stat
);
	import abkf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_MUL, S_WB, S_DIVI, S_DIV, S_FIN, S_DONE
	} state_t;

	state_t  state_q;
	mul_op_t op_q;
	logic    out_valid_q;
	logic    accept;
	logic    out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// decode commands from the state
	always_comb begin
		cmd          = '0;
		cmd.op       = op_q;
		cmd.take     = accept;
		cmd.load_rst = (state_q == S_LOAD);
		cmd.mul      = (state_q == S_MUL);
		cmd.wb       = (state_q == S_WB);
		cmd.div_init = (state_q == S_DIVI);
		cmd.div_step = (state_q == S_DIV);
		cmd.div_fin  = (state_q == S_FIN);
		cmd.out_load = (state_q == S_DONE) && out_free;
	end

	// hold state, advance through the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_RATE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= OP_RATE;
						state_q <= (action == ActReset) ? S_LOAD : S_MUL;
					end
				end
				S_LOAD: state_q <= S_DONE;
				S_MUL:  state_q <= S_WB;
				S_WB: begin
					state_q <= S_MUL;
					case (op_q)
						OP_RATE:     op_q <= OP_DT_P11;
						OP_DT_P11:   op_q <= OP_DT_INNER;
						OP_DT_INNER: op_q <= OP_DT_BN;
						OP_DT_BN:    state_q <= S_DIVI;
						OP_K0Y:      op_q <= OP_K1Y;
						OP_K1Y:      op_q <= OP_K1P00;
						OP_K1P00:    op_q <= OP_K1P01;
						OP_K1P01:    op_q <= OP_K0P00;
						OP_K0P00:    op_q <= OP_K0P01;
						default:     state_q <= S_DONE;
					endcase
				end
				S_DIVI: state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					op_q    <= OP_K0Y;
					state_q <= S_MUL;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/abkf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abkf_dpath: filter state and arithmetic
// Holds the estimates, covariance and noise registers, one shared multiplier
// with a product register, and two bit-serial gain dividers run side by side.
// ----------------------------------------------------------------------------
module abkf_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire abkf_pkg::in_word_t             in_data,
	output abkf_pkg::out_word_t                 out_data,
	input  wire logic                           cfg_valid,
	input  wire logic [abkf_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [abkf_pkg::CfgDataW-1:0]  cfg_data,
	input  wire abkf_pkg::dp_cmd_t              cmd,
	output abkf_pkg::dp_stat_t                  stat
);
	import abkf_pkg::*;

	logic [CfgDataW-1:0] an_q, bn_q, mn_q;
	in_word_t            in_q;
	out_word_t           out_q;
	logic signed [31:0]  ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [35:0]  inner_q;
	logic signed [31:0]  y_q, k0_q, k1_q;
	logic signed [68:0]  prod_s1;
	mul_op_t             op_s1;

	logic signed [35:0]  a_op;
	logic signed [32:0]  b_op;
	logic signed [32:0]  dt33;
	logic signed [32:0]  rate;
	logic signed [69:0]  r16, r24;
	logic signed [35:0]  t36, inner_n;

	// divider state
	logic signed [33:0]  s_q;
	logic [33:0]         r0_q, r1_q;
	logic [30:0]         nb0_q, nb1_q, q0_q, q1_q;
	logic                sat0_q, sat1_q, neg0_q, neg1_q;
	logic [DivCntW-1:0]  cnt_q;
	logic signed [33:0]  s_n;
	logic [32:0]         m0w, m1w;
	logic [31:0]         mag0, mag1;
	logic [33:0]         r0x, r1x;
	logic                ge0, ge1;

	assign out_data      = out_q;
	assign stat.div_last = (cnt_q == DivCntW'(DivSteps - 1));

	// select multiplier operands
	assign dt33 = {17'd0, in_q.time_step};
	assign rate = {in_q.gyro_rate[31], in_q.gyro_rate} - {bias_q[31], bias_q};
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (cmd.op)
			OP_RATE:     begin a_op = {{3{rate[32]}}, rate};         b_op = dt33; end
			OP_DT_P11:   begin a_op = {{4{p11_q[31]}}, p11_q};       b_op = dt33; end
			OP_DT_INNER: begin a_op = inner_q;                       b_op = dt33; end
			OP_DT_BN:    begin a_op = {5'd0, bn_q};                  b_op = dt33; end
			OP_K0Y:      begin a_op = {{4{k0_q[31]}}, k0_q}; b_op = {y_q[31], y_q};     end
			OP_K1Y:      begin a_op = {{4{k1_q[31]}}, k1_q}; b_op = {y_q[31], y_q};     end
			OP_K1P00:    begin a_op = {{4{k1_q[31]}}, k1_q}; b_op = {p00_q[31], p00_q}; end
			OP_K1P01:    begin a_op = {{4{k1_q[31]}}, k1_q}; b_op = {p01_q[31], p01_q}; end
			OP_K0P00:    begin a_op = {{4{k0_q[31]}}, k0_q}; b_op = {p00_q[31], p00_q}; end
			OP_K0P01:    begin a_op = {{4{k0_q[31]}}, k0_q}; b_op = {p01_q[31], p01_q}; end
			default:     begin a_op = '0; b_op = '0; end
		endcase
	end

	// rescale the product for write-back
	assign r16     = rnd_shr(prod_s1, 16);
	assign r24     = rnd_shr(prod_s1, 24);
	assign t36     = r16[35:0];
	assign inner_n = t36 - {{4{p01_q[31]}}, p01_q} - {{4{p10_q[31]}}, p10_q}
		+ {5'd0, an_q};

	// divider set-up values
	assign s_n  = {{2{p00_q[31]}}, p00_q} + {3'd0, mn_q};
	assign m0w  = p00_q[31] ? (33'd0 - {p00_q[31], p00_q}) : {p00_q[31], p00_q};
	assign m1w  = p10_q[31] ? (33'd0 - {p10_q[31], p10_q}) : {p10_q[31], p10_q};
	assign mag0 = m0w[31:0];
	assign mag1 = m1w[31:0];
	assign r0x  = {r0_q[32:0], nb0_q[30]};
	assign r1x  = {r1_q[32:0], nb1_q[30]};
	assign ge0  = (r0x >= $unsigned(s_q));
	assign ge1  = (r1x >= $unsigned(s_q));

	// write configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			an_q <= AngleNoiseRst;
			bn_q <= BiasNoiseRst;
			mn_q <= MeasureNoiseRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegAngleNoise:   an_q <= cfg_data;
				RegBiasNoise:    bn_q <= cfg_data;
				RegMeasureNoise: mn_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q  <= '0;
			bias_q <= '0;
			p00_q  <= OneQ24;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= OneQ24;
		end else if (cmd.load_rst) begin
			ang_q  <= in_q.start_angle;
			bias_q <= in_q.start_bias;
			p00_q  <= OneQ24;
			p01_q  <= '0;
			p10_q  <= '0;
			p11_q  <= OneQ24;
		end else if (cmd.wb) begin
			case (op_s1)
				OP_RATE:     ang_q <= sat32(sx70(ang_q) + r16);
				OP_DT_P11: begin
					p01_q <= sat32(sx70(p01_q) - r16);
					p10_q <= sat32(sx70(p10_q) - r16);
				end
				OP_DT_INNER: p00_q  <= sat32(sx70(p00_q) + r16);
				OP_DT_BN:    p11_q  <= sat32(sx70(p11_q) + r16);
				OP_K0Y:      ang_q  <= sat32(sx70(ang_q) + r24);
				OP_K1Y:      bias_q <= sat32(sx70(bias_q) + r24);
				OP_K1P00:    p10_q  <= sat32(sx70(p10_q) - r24);
				OP_K1P01:    p11_q  <= sat32(sx70(p11_q) - r24);
				OP_K0P00:    p00_q  <= sat32(sx70(p00_q) - r24);
				OP_K0P01:    p01_q  <= sat32(sx70(p01_q) - r24);
				default:     ;
			endcase
		end
	end

	// capture the input word, multiply, hold working values
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_q <= in_data;
		end
		if (cmd.mul) begin
			prod_s1 <= a_op * b_op;
			op_s1   <= cmd.op;
		end
		if (cmd.wb && op_s1 == OP_DT_P11) begin
			inner_q <= inner_n;
		end
		if (cmd.out_load) begin
			out_q.filtered_angle <= ang_q;
			out_q.estimated_bias <= bias_q;
		end
	end

	// two restoring dividers, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			s_q    <= s_n;
			y_q    <= sat32(sx70(in_q.measured_angle) - sx70(ang_q));
			neg0_q <= p00_q[31];
			neg1_q <= p10_q[31];
			sat0_q <= ({8'd0, mag0} >= {s_n[32:0], 7'd0});
			sat1_q <= ({8'd0, mag1} >= {s_n[32:0], 7'd0});
			r0_q   <= {9'd0, mag0[31:7]};
			r1_q   <= {9'd0, mag1[31:7]};
			nb0_q  <= {mag0[6:0], 24'd0};
			nb1_q  <= {mag1[6:0], 24'd0};
		end else if (cmd.div_step) begin
			r0_q  <= ge0 ? (r0x - $unsigned(s_q)) : r0x;
			r1_q  <= ge1 ? (r1x - $unsigned(s_q)) : r1x;
			q0_q  <= {q0_q[29:0], ge0};
			q1_q  <= {q1_q[29:0], ge1};
			nb0_q <= {nb0_q[29:0], 1'b0};
			nb1_q <= {nb1_q[29:0], 1'b0};
		end
		// sign, saturate and gate the gains
		if (cmd.div_fin) begin
			if (s_q <= 34'sd0) begin
				k0_q <= '0;
				k1_q <= '0;
			end else begin
				if (sat0_q) k0_q <= neg0_q ? Min32 : Max32;
				else        k0_q <= neg0_q ? (32'sd0 - {1'b0, q0_q}) : {1'b0, q0_q};
				if (sat1_q) k1_q <= neg1_q ? Min32 : Max32;
				else        k1_q <= neg1_q ? (32'sd0 - {1'b0, q1_q}) : {1'b0, q1_q};
			end
		end
	end

endmodule
`default_nettype wire

FILE: src/angle_bias_kalman_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter_unit: two-state angle and gyro-bias Kalman filter
// Fuses an angle measurement with a gyro rate; fixed point throughout.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_stall/in_data; a word is taken when
//   in_valid is high and in_stall low. Each word yields one result word on
//   out_valid/out_stall/out_data. Noise registers are written through
//   cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
//   writes to index 3 are dropped. Write them only while the block is idle.
//   Sequence: a reset word loads the start values and goes to the result;
//   an update word runs four multiply/write-back pairs on the single shared
//   multiplier, the divider set-up, the bit-serial gain dividers, the gain
//   finish step and six more pairs. One word is worked on at a time: no new
//   word is taken until the current one has given its result.
//   The next word may be taken while a result still waits in the output
//   register; a stalled result holds and the sequencer then waits at its
//   final step until the register is free.
//   Reset clears the estimates, loads an identity covariance and the default
//   noise values.
// ----------------------------------------------------------------------------
module angle_bias_kalman_filter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire abkf_pkg::in_word_t             in_data,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output abkf_pkg::out_word_t                 out_data,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [abkf_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [abkf_pkg::CfgDataW-1:0]  cfg_data
);
	import abkf_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	abkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (in_data.action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	abkf_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// busy right after a word is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken but block not busy");

	// a new result only comes out of a running item
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a running item");

	// multiplier and divider never commanded together
	a_excl_units: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul && (cmd.div_step || cmd.div_init)))
		else $error("multiplier and divider commanded together");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the angle/bias Kalman filter unit
// Drives reset and update words under several idle and stall patterns and
// rewrites the noise registers between phases. A bit-true fixed-point filter
// inside the bench predicts each filtered angle and bias. Every result word is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import abkf_pkg::*;

	localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
	localparam int unsigned CycleLimit = 1500000;
	localparam int unsigned DrainCycles = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	// idle and stall rates, percent
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	out_word_t filtered_q[$];

	// predictor copy of the filter state and noise registers
	longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
	longint noise_angle, noise_bias, noise_meas;

	angle_bias_kalman_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// round half up of x / 2^n
	function automatic longint round_shr(longint x, int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint kalman_gain(longint num, longint s);
		if (s <= 0) return 0;
		return clamp32((num * 64'sd16777216) / s);
	endfunction

	// advance the predictor by one word and return the expected result
	function automatic out_word_t filter_step(in_word_t w);
		longint z, g, dt, q00, q01, q10, q11, inner, s, k0, k1, y;
		out_word_t r;
		if (w.action == ActReset) begin
			est_angle = longint'(w.start_angle);
			est_bias = longint'(w.start_bias);
			p_aa = 64'sd16777216;
			p_ab = 0;
			p_ba = 0;
			p_bb = 64'sd16777216;
		end else begin
			z = longint'(w.measured_angle);
			g = longint'(w.gyro_rate);
			dt = longint'({48'd0, w.time_step});
			q00 = p_aa; q01 = p_ab; q10 = p_ba; q11 = p_bb;
			est_angle = clamp32(est_angle + round_shr((g - est_bias) * dt, 16));
			inner = round_shr(dt * q11, 16) - q01 - q10 + noise_angle;
			p_aa = clamp32(q00 + round_shr(dt * inner, 16));
			p_ab = clamp32(q01 - round_shr(dt * q11, 16));
			p_ba = clamp32(q10 - round_shr(dt * q11, 16));
			p_bb = clamp32(q11 + round_shr(noise_bias * dt, 16));
			q00 = p_aa;
			q01 = p_ab;
			s = q00 + noise_meas;
			k0 = kalman_gain(q00, s);
			k1 = kalman_gain(p_ba, s);
			y = clamp32(z - est_angle);
			est_angle = clamp32(est_angle + round_shr(k0 * y, 24));
			est_bias = clamp32(est_bias + round_shr(k1 * y, 24));
			p_aa = clamp32(q00 - round_shr(k0 * q00, 24));
			p_ab = clamp32(q01 - round_shr(k0 * q01, 24));
			p_ba = clamp32(p_ba - round_shr(k1 * q00, 24));
			p_bb = clamp32(p_bb - round_shr(k1 * q01, 24));
		end
		r.filtered_angle = est_angle[31:0];
		r.estimated_bias = est_bias[31:0];
		return r;
	endfunction

	// send one word, idling first at the current rate
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		filtered_q.push_back(filter_step(w));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			RegAngleNoise: noise_angle = longint'({33'd0, val});
			RegBiasNoise: noise_bias = longint'({33'd0, val});
			RegMeasureNoise: noise_meas = longint'({33'd0, val});
			default: ;
		endcase
	endtask

	// wait until every result word has arrived, then let the pipe settle
	task automatic drain;
		in_valid <= 1'b0;
		while (filtered_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_noise(logic [30:0] a, logic [30:0] b, logic [30:0] m);
		write_reg(RegAngleNoise, a);
		write_reg(RegBiasNoise, b);
		write_reg(RegMeasureNoise, m);
	endtask

	function automatic in_word_t make_word(logic act, int z, int g, int dt,
			int sa, int sb);
		in_word_t w;
		w.action = act;
		w.measured_angle = z;
		w.gyro_rate = g;
		w.time_step = dt[15:0];
		w.start_angle = sa;
		w.start_bias = sb;
		return w;
	endfunction

	// mostly plausible motion with occasional full-range words and resets
	function automatic in_word_t random_word;
		in_word_t w;
		w.measured_angle = $urandom;
		w.gyro_rate = $urandom;
		w.start_angle = $urandom;
		w.start_bias = $urandom;
		w.time_step = 16'($urandom);
		w.action = ($urandom_range(99) < 6) ? ActReset : ActUpdate;
		if ($urandom_range(99) < 75) begin
			w.measured_angle = int'($urandom_range(0, 23592960)) - 11796480;
			w.gyro_rate = int'($urandom_range(0, 32768000)) - 16384000;
			w.start_angle = int'($urandom_range(0, 2000000)) - 1000000;
			w.start_bias = int'($urandom_range(0, 200000)) - 100000;
			w.time_step = 16'($urandom_range(0, 3000));
		end
		return w;
	endfunction

	task automatic test_directed;
		send_word(make_word(ActUpdate, 0, 0, 0, 0, 0));
		send_word(make_word(ActUpdate, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0));
		send_word(make_word(ActUpdate, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 0, 0));
		send_word(make_word(ActReset, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
		send_word(make_word(ActUpdate, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0, 0));
		send_word(make_word(ActReset, -1, -1, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		send_word(make_word(ActUpdate, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0));
		send_word(make_word(ActReset, 0, 0, 0, 0, 0));
		send_word(make_word(ActUpdate, 65536, 6553600, 655, 0, 0));
		send_word(make_word(ActUpdate, 131072, 6553600, 655, 0, 0));
		drain();
		// zero measurement noise gives unity angle gain
		set_noise(31'd0, 31'd0, 31'd0);
		send_word(make_word(ActUpdate, 12345678, -9876543, 1000, 0, 0));
		send_word(make_word(ActUpdate, -5, 5, 0, 0, 0));
		drain();
		// maximum noise pushes the covariance into saturation
		set_noise(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		write_reg(RegUnused, 31'h1234_5678);
		repeat (6) send_word(make_word(ActUpdate, 32'h7FFF_FFFF, 32'h8000_0000,
			16'hFFFF, 0, 0));
		send_word(make_word(ActUpdate, -100000, 100000, 16'hFFFF, 0, 0));
		drain();
	endtask

	task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_word(random_word());
		drain();
	endtask

	task automatic test_noise_sweep;
		set_noise(AngleNoiseRst, BiasNoiseRst, MeasureNoiseRst);
		test_random(350, 0, 0);
		set_noise(31'($urandom), 31'($urandom), 31'($urandom_range(1, 31'h7FFF_FFFF)));
		test_random(350, 88, 0);
		set_noise(31'($urandom_range(0, 2000000)), 31'($urandom_range(0, 2000000)),
			31'($urandom_range(1, 20000000)));
		test_random(350, 0, 88);
		set_noise(31'd0, 31'd0, 31'd1);
		test_random(350, 30, 30);
		set_noise(31'($urandom), 31'($urandom), 31'($urandom));
		test_random(350, 30, 30);
	endtask

	// check each result word and drive the result stall
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (filtered_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", out_data);
			end else begin
				want = filtered_q.pop_front();
				if (out_data.filtered_angle !== want.filtered_angle ||
						out_data.estimated_bias !== want.estimated_bias) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: angle exp %h got %h, bias exp %h got %h",
							want.filtered_angle, out_data.filtered_angle,
							want.estimated_bias, out_data.estimated_bias);
				end
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		noise_angle = longint'(AngleNoiseRst);
		noise_bias = longint'(BiasNoiseRst);
		noise_meas = longint'(MeasureNoiseRst);
		est_angle = 0;
		est_bias = 0;
		p_aa = 64'sd16777216;
		p_ab = 0;
		p_ba = 0;
		p_bb = 64'sd16777216;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_noise_sweep();
		if (mismatches == 0 && filtered_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
